[rtl/ufg_pkg.sv]
// Shared types, constants and register codes of the UDP frame generator.
// No dependencies; every other file of the block imports this package.
package ufg_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES     = 64;
  localparam int unsigned BEATS_PER_FRAME = FRAME_BYTES / 8;
  localparam int unsigned BEAT_W          = $clog2(BEATS_PER_FRAME);

  // Request limits
  localparam logic [3:0] MAX_FRAMES = 4'd8;

  // Fixed header fields
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'(FRAME_BYTES - 14);
  localparam logic [7:0]  IP_TTL         = 8'h40;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
  localparam logic [15:0] UDP_LEN        = 16'(FRAME_BYTES - 34);
  localparam logic [15:0] UDP_PORT_RESET = 16'd8080;

  // Sum of the header words that never change (version/IHL/TOS, length, TTL/proto)
  localparam logic [15:0] CSUM_FIXED = {IP_VER_IHL, 8'h00} + IP_TOTAL_LEN
                                       + {IP_TTL, IP_PROTO_UDP};

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEST_MAC   = 3'd0,
    CFG_SOURCE_MAC = 3'd1,
    CFG_SOURCE_IP  = 3'd2,
    CFG_DEST_IP    = 3'd3,
    CFG_SRC_PORT   = 3'd4,
    CFG_DST_PORT   = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 48;

  // Configuration seen by the beat formatter
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
    logic [15:0] ip_checksum;
  } cfg_t;

  // One beat request from the sequencer to the formatter
  typedef struct packed {
    logic              valid;
    logic [BEAT_W-1:0] index;
    logic [31:0]       seq;
    logic              frame_end;
    logic              burst_end;
  } beat_req_t;

endpackage

[rtl/ufg_if.sv]
// Valid/ready channel interfaces of the UDP frame generator.
// Depends on ufg_pkg for the beat index width.
interface ufg_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink   (input valid, input frame_count, output ready);
endinterface

interface ufg_beat_if;
  import ufg_pkg::*;
  logic              valid;
  logic              ready;
  logic [63:0]       beat_data;
  logic [BEAT_W-1:0] beat_index;
  logic              frame_end;
  logic [31:0]       sequence_number;
  logic              burst_end;

  modport source (output valid, output beat_data, output beat_index, output frame_end,
                  output sequence_number, output burst_end, input ready);
  modport sink   (input valid, input beat_data, input beat_index, input frame_end,
                  input sequence_number, input burst_end, output ready);
endinterface

[rtl/ufg_cfg.sv]
// Configuration registers and the registered IPv4 header checksum.
// Depends on ufg_pkg.
module ufg_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [ufg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ufg_pkg::cfg_t                  cfg_o
);
  import ufg_pkg::*;

  logic [47:0] dest_mac_q, source_mac_q;
  logic [31:0] source_ip_q, dest_ip_q;
  logic [15:0] src_port_q, dst_port_q;
  logic [15:0] csum_q, csum_d;
  logic [18:0] sum_raw;
  logic [16:0] sum_fold1;
  logic [15:0] sum_fold2;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_mac_q   <= '0;
      source_mac_q <= '0;
      source_ip_q  <= '0;
      dest_ip_q    <= '0;
      src_port_q   <= UDP_PORT_RESET;
      dst_port_q   <= UDP_PORT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEST_MAC:   dest_mac_q   <= cfg_data_i[47:0];
        CFG_SOURCE_MAC: source_mac_q <= cfg_data_i[47:0];
        CFG_SOURCE_IP:  source_ip_q  <= cfg_data_i[31:0];
        CFG_DEST_IP:    dest_ip_q    <= cfg_data_i[31:0];
        CFG_SRC_PORT:   src_port_q   <= cfg_data_i[15:0];
        CFG_DST_PORT:   dst_port_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Ones-complement sum of the header words, two end-around folds
  always_comb begin
    sum_raw   = 19'(CSUM_FIXED) + 19'(source_ip_q[31:16]) + 19'(source_ip_q[15:0])
              + 19'(dest_ip_q[31:16]) + 19'(dest_ip_q[15:0]);
    sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
    sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);
    csum_d    = ~sum_fold2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= ~CSUM_FIXED;
    end else begin
      csum_q <= csum_d;
    end
  end

  assign cfg_o = '{dest_mac:        dest_mac_q,
                   source_mac:      source_mac_q,
                   source_ip:       source_ip_q,
                   dest_ip:         dest_ip_q,
                   udp_source_port: src_port_q,
                   udp_dest_port:   dst_port_q,
                   ip_checksum:     csum_q};

endmodule

[rtl/ufg_seq.sv]
// Burst sequencer: request holding register, frame/beat counters, sequence number.
// Depends on ufg_pkg and ufg_req_if.
module ufg_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  ufg_req_if.sink            req,
  input  logic               advance_i,
  output ufg_pkg::beat_req_t beat_req_o
);
  import ufg_pkg::*;

  logic              pend_q, pend_d;
  logic [3:0]        pend_cnt_q, pend_cnt_d;
  logic              act_q, act_d;
  logic [3:0]        frames_q, frames_d;
  logic [BEAT_W-1:0] beat_q, beat_d;
  logic [31:0]       seq_q, seq_d;
  logic              frame_last, burst_last, take_req, req_fire;

  assign frame_last = (beat_q == BEAT_W'(BEATS_PER_FRAME - 1));
  assign burst_last = frame_last && (frames_q == 4'd1);
  // Pending request moves into the counters once the running burst ends
  assign take_req   = pend_q && (!act_q || (advance_i && burst_last));
  assign req.ready  = !pend_q || take_req;
  assign req_fire   = req.valid && req.ready;

  // Next-state logic
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    act_d      = act_q;
    frames_d   = frames_q;
    beat_d     = beat_q;
    seq_d      = seq_q;

    if (act_q && advance_i) begin
      beat_d = beat_q + BEAT_W'(1);
      if (frame_last) begin
        seq_d    = seq_q + 32'd1;
        frames_d = frames_q - 4'd1;
        if (burst_last) begin
          act_d = 1'b0;
        end
      end
    end

    if (take_req) begin
      pend_d   = 1'b0;
      act_d    = 1'b1;
      frames_d = pend_cnt_q;
      beat_d   = '0;
    end

    // A zero-frame request is taken and dropped
    if (req_fire && (req.frame_count != 4'd0)) begin
      pend_d     = 1'b1;
      pend_cnt_d = (req.frame_count > MAX_FRAMES) ? MAX_FRAMES : req.frame_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      act_q    <= 1'b0;
      frames_q <= '0;
      beat_q   <= '0;
      seq_q    <= '0;
    end else begin
      pend_q   <= pend_d;
      act_q    <= act_d;
      frames_q <= frames_d;
      beat_q   <= beat_d;
      seq_q    <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cnt_q <= pend_cnt_d;
  end

  assign beat_req_o = '{valid:     act_q,
                        index:     beat_q,
                        seq:       seq_q,
                        frame_end: frame_last,
                        burst_end: burst_last};

endmodule

[rtl/ufg_beat.sv]
// Beat formatter: builds the 64-bit word for a beat and holds the output register.
// Depends on ufg_pkg and ufg_beat_if.
module ufg_beat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ufg_pkg::cfg_t      cfg_i,
  input  ufg_pkg::beat_req_t beat_req_i,
  output logic               advance_o,
  ufg_beat_if.source         beat
);
  import ufg_pkg::*;

  logic              valid_q, valid_d;
  logic [63:0]       data_q, data_d;
  logic [BEAT_W-1:0] index_q;
  logic [31:0]       seq_q;
  logic              frame_end_q, burst_end_q;

  // Output register takes a new word when empty or being taken
  assign advance_o = !valid_q || beat.ready;
  assign valid_d   = advance_o ? beat_req_i.valid : valid_q;

  // Frame bytes of each beat, earliest wire byte on top
  always_comb begin
    case (beat_req_i.index)
      3'd0: data_d = {cfg_i.dest_mac, cfg_i.source_mac[47:32]};
      3'd1: data_d = {cfg_i.source_mac[31:0], ETH_TYPE_IPV4, IP_VER_IHL, 8'h00};
      3'd2: data_d = {IP_TOTAL_LEN, 32'h0, IP_TTL, IP_PROTO_UDP};
      3'd3: data_d = {cfg_i.ip_checksum, cfg_i.source_ip, cfg_i.dest_ip[31:16]};
      3'd4: data_d = {cfg_i.dest_ip[15:0], cfg_i.udp_source_port,
                      cfg_i.udp_dest_port, UDP_LEN};
      3'd5: data_d = {16'h0, beat_req_i.seq, 16'h0};
      default: data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      data_q      <= data_d;
      index_q     <= beat_req_i.index;
      seq_q       <= beat_req_i.seq;
      frame_end_q <= beat_req_i.frame_end;
      burst_end_q <= beat_req_i.burst_end;
    end
  end

  assign beat.valid           = valid_q;
  assign beat.beat_data       = data_q;
  assign beat.beat_index      = index_q;
  assign beat.frame_end       = frame_end_q;
  assign beat.sequence_number = seq_q;
  assign beat.burst_end       = burst_end_q;

endmodule

[rtl/udp_frame_generator.sv]
// An accepted request waits in the pending register until a running burst ends, then
// starts the sequencer; its first beat goes to the output register. Throughput: one
// 64-bit beat per cycle while the sink is ready; the next request follows with no gap.
// Reset: registers return to defaults (MACs/IPs 0, ports 8080), sequence number to 0,
// no request pending and no beat valid.
module udp_frame_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ufg_req_if.sink                        req,
  ufg_beat_if.source                     beat,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [ufg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ufg_pkg::*;

  cfg_t      cfg;
  beat_req_t beat_req;
  logic      advance;

  ufg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ufg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .advance_i  (advance),
    .beat_req_o (beat_req)
  );

  ufg_beat u_beat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .beat_req_i (beat_req),
    .advance_o  (advance),
    .beat       (beat)
  );

`ifndef SYNTH
  // Frame end marks exactly the last beat of a frame
  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.valid |-> (beat.frame_end == (beat.beat_index == BEAT_W'(BEATS_PER_FRAME - 1))))
    else $error("frame_end not on last beat");

  // Burst end only on a frame end
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat.valid && beat.burst_end) |-> beat.frame_end)
    else $error("burst_end without frame_end");

  // Within a frame the next beat follows at once with the next index
  a_beat_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat.valid && beat.ready && !beat.frame_end) |=>
      (beat.valid && (beat.beat_index == ($past(beat.beat_index) + BEAT_W'(1)))))
    else $error("beat sequence broken within frame");
`endif

endmodule

[sim/udp_frame_generator_tb.sv]
// Testbench for udp_frame_generator: random and directed frame-burst requests,
// every beat checked against an in-bench frame builder. Depends on ufg_pkg, ufg_if
// and the RTL top; needs nothing else.
module udp_frame_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ufg_pkg::*;

  // Header fields as they appear on the wire
  localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
  localparam logic [7:0]  V4_VER_IHL   = 8'h45;
  localparam logic [15:0] V4_TOTAL_LEN = 16'd50;
  localparam logic [7:0]  V4_TTL       = 8'h40;
  localparam logic [7:0]  V4_PROTO     = 8'd17;
  localparam logic [15:0] UDP_LENGTH   = 16'd30;
  localparam logic [15:0] PORT_DEFAULT = 16'd8080;

  localparam int unsigned BURST_FRAMES_MAX = 8;
  localparam int unsigned BEATS_IN_FRAME   = 8;

  // Register indexes with no register behind them
  localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;

  // Cycles to let pass once the last expected word arrived
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PER_PHASE = 50;

  typedef struct packed {
    logic [63:0]       data;
    logic [BEAT_W-1:0] index;
    logic              frame_end;
    logic [31:0]       seq;
    logic              burst_end;
  } beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [2:0]            cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ufg_req_if  req_ch ();
  ufg_beat_if beat_ch ();

  udp_frame_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .beat       (beat_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Bench copy of the configuration and the sequence counter
  logic [47:0] dest_mac_q;
  logic [47:0] source_mac_q;
  logic [31:0] source_ip_q;
  logic [31:0] dest_ip_q;
  logic [15:0] src_port_q;
  logic [15:0] dst_port_q;
  logic [31:0] frame_seq_q;

  beat_t       expected_beats[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("udp_frame_generator verification failed");
    $finish;
  end

  // Sink: random backpressure
  always @(posedge clk_i) begin
    beat_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Check each accepted word against the oldest expectation
  always @(posedge clk_i) begin : beat_check
    beat_t want;
    if (rst_ni && beat_ch.valid && beat_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("word with nothing expected", beat_ch.beat_data, '0);
      end else begin
        want = expected_beats.pop_front();
        if (beat_ch.beat_data !== want.data)
          report_mismatch("beat_data", beat_ch.beat_data, want.data);
        if (beat_ch.beat_index !== want.index)
          report_mismatch("beat_index", 64'(beat_ch.beat_index), 64'(want.index));
        if (beat_ch.frame_end !== want.frame_end)
          report_mismatch("frame_end", 64'(beat_ch.frame_end), 64'(want.frame_end));
        if (beat_ch.sequence_number !== want.seq)
          report_mismatch("sequence_number", 64'(beat_ch.sequence_number), 64'(want.seq));
        if (beat_ch.burst_end !== want.burst_end)
          report_mismatch("burst_end", 64'(beat_ch.burst_end), 64'(want.burst_end));
      end
    end
  end

  // Ones-complement IPv4 header checksum; the checksum word counts as zero
  function automatic logic [15:0] ipv4_checksum(input logic [31:0] sip,
                                                input logic [31:0] dip);
    logic [31:0] acc;
    acc = {V4_VER_IHL, 8'h00} + V4_TOTAL_LEN + {V4_TTL, V4_PROTO}
          + sip[31:16] + sip[15:0] + dip[31:16] + dip[15:0];
    acc = (acc & 32'hffff) + (acc >> 16);
    acc = (acc & 32'hffff) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  // Build the frames of one request and queue their words
  task automatic queue_burst_beats(input logic [3:0] count);
    int unsigned  frames;
    logic [511:0] frame;
    beat_t        b;
    frames = (count > BURST_FRAMES_MAX) ? BURST_FRAMES_MAX : int'(count);
    for (int f = 0; f < frames; f++) begin
      frame = {dest_mac_q, source_mac_q, ETHERTYPE_V4,
               V4_VER_IHL, 8'h00, V4_TOTAL_LEN, 16'h0000, 16'h0000,
               V4_TTL, V4_PROTO, ipv4_checksum(source_ip_q, dest_ip_q),
               source_ip_q, dest_ip_q,
               src_port_q, dst_port_q, UDP_LENGTH, 16'h0000,
               frame_seq_q, 144'h0};
      for (int k = 0; k < BEATS_IN_FRAME; k++) begin
        b.data      = frame[511 - 64 * k -: 64];
        b.index     = BEAT_W'(k);
        b.frame_end = (k == BEATS_IN_FRAME - 1);
        b.seq       = frame_seq_q;
        b.burst_end = b.frame_end && (f == frames - 1);
        expected_beats.push_back(b);
      end
      frame_seq_q = frame_seq_q + 32'd1;
    end
  endtask

  // Offer one request, with random idle cycles first; valid stays high on return
  task automatic send_request(input logic [3:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.frame_count <= count;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    queue_burst_beats(count);
  endtask

  // Wait until every expected word arrived, plus time for zero-count requests
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; write enable is left high for the caller to drop
  task automatic cfg_write(input logic [2:0] idx, input logic [47:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_DEST_MAC:   dest_mac_q   = value;
      CFG_SOURCE_MAC: source_mac_q = value;
      CFG_SOURCE_IP:  source_ip_q  = value[31:0];
      CFG_DEST_IP:    dest_ip_q    = value[31:0];
      CFG_SRC_PORT:   src_port_q   = value[15:0];
      CFG_DST_PORT:   dst_port_q   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_config(input logic [47:0] dmac, input logic [47:0] smac,
                                input logic [47:0] sip, input logic [47:0] dip,
                                input logic [47:0] sport, input logic [47:0] dport);
    wait_quiet();
    cfg_write(CFG_DEST_MAC, dmac);
    cfg_write(CFG_SOURCE_MAC, smac);
    cfg_write(CFG_SOURCE_IP, sip);
    cfg_write(CFG_DEST_IP, dip);
    cfg_write(CFG_SRC_PORT, sport);
    cfg_write(CFG_DST_PORT, dport);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Random frame count: mostly legal, some zero and some above the cap
  function automatic logic [3:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return 4'd0;
    if (pick < 15) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(8, 1));
  endfunction

  // Defaults out of reset: zero addresses, port 8080 both ways
  task automatic test_reset_defaults();
    send_request(4'd1);
  endtask

  // All-ones and all-zero settings; all-ones pushes the checksum carries hardest
  task automatic test_config_extremes();
    program_config('1, '1, '1, '1, '1, '1);
    send_request(4'd1);
    program_config('0, '0, '0, '0, '0, '0);
    send_request(4'd1);
  endtask

  // Writes to unused indexes must leave every register alone
  task automatic test_spare_register_index();
    program_config(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
    cfg_write(CFG_IDX_SPARE_LO, '1);
    cfg_write(CFG_IDX_SPARE_HI, rand48());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_request(4'd2);
  endtask

  // Every count: zero gives nothing, above eight saturates to eight frames
  task automatic test_burst_lengths();
    for (int c = 0; c < 16; c++) send_request(4'(c));
  endtask

  // Random requests under each idling mix, fresh random setup per phase
  task automatic test_random_traffic();
    int unsigned idle_mix[4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{34, 34}};
    for (int p = 0; p < 4; p++) begin
      program_config(rand48(), rand48(), rand48(), rand48(),
                     48'($urandom_range(16'hffff)), 48'($urandom_range(16'hffff)));
      send_idle_pct  = idle_mix[p][0];
      sink_stall_pct = idle_mix[p][1];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(rand_count());
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_DEST_MAC;
    cfg_data_i         <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.frame_count <= '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    dest_mac_q     = '0;
    source_mac_q   = '0;
    source_ip_q    = '0;
    dest_ip_q      = '0;
    src_port_q     = PORT_DEFAULT;
    dst_port_q     = PORT_DEFAULT;
    frame_seq_q    = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_spare_register_index();
    test_burst_lengths();
    test_random_traffic();

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("udp_frame_generator verification clean");
    end else begin
      $display("udp_frame_generator verification failed");
    end
    $finish;
  end

endmodule
